[rtl/cmo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmo_pkg
// Shared types, constants and the Q3.12 rounding function of the channel
// mixer.
// ----------------------------------------------------------------------------
package cmo_pkg;

    localparam int LANES        = 8;
    localparam int CH_LIMIT_DEF = 8;

    // Full-scale limits, PCM16 scale with 8 fraction bits
    localparam logic signed [47:0] FULL_POS = 48'sd8388352;
    localparam logic signed [47:0] FULL_NEG = -48'sd8388608;

    // Configuration register indexes
    localparam logic [2:0] REG_OP_MODE     = 3'd0;
    localparam logic [2:0] REG_CHANNELS_IN = 3'd1;
    localparam logic [2:0] REG_SRC_CHANNEL = 3'd2;
    localparam logic [2:0] REG_DST_CHANNEL = 3'd3;
    localparam logic [2:0] REG_GAIN        = 3'd4;

    typedef enum logic [2:0] {
        MODE_SWAP    = 3'd0,
        MODE_ADD     = 3'd1,
        MODE_VOLUME  = 3'd2,
        MODE_LIMIT   = 3'd3,
        MODE_UPMIX   = 3'd4,
        MODE_DOWNMIX = 3'd5,
        MODE_KILLMIX = 3'd6
    } mode_t;

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic [2:0]        mode;
        logic [3:0]        cnt;
        logic [2:0]        src;
        logic signed [4:0] dst;
        logic              last;
    } ctrl_t;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic signed [31:0] sample;
        logic signed [31:0] scaled;
        logic               sat;
    } lane_t;

    // Round a Q3.12 product to nearest, ties toward plus infinity
    function automatic logic signed [36:0] scale_round(input logic signed [47:0] p);
        logic signed [48:0] biased;
        begin
            biased = {p[47], p} + 49'sd2048;
            return biased[48:12];
        end
    endfunction

endpackage
`default_nettype wire

[rtl/cmo_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmo_lane
// One channel lane: multiply the sample by the gain, then round and
// saturate the product to 32 bits. Two register stages.
// ----------------------------------------------------------------------------
module cmo_lane (
    input  wire logic               clk,
    input  wire logic signed [31:0] sample,
    input  wire logic               keep,
    input  wire logic signed [15:0] gain,
    output cmo_pkg::lane_t          lane_b
);

    logic signed [31:0] a_sample_reg;
    logic signed [47:0] a_prod_reg;
    logic signed [31:0] a_sample_next;
    logic signed [47:0] a_prod_next;
    logic signed [36:0] rnd;
    cmo_pkg::lane_t     b_next;
    cmo_pkg::lane_t     b_reg;

    always_comb
    begin
        a_sample_next = keep ? sample : 32'sd0;
        a_prod_next   = a_sample_next * gain;
    end

    always_comb
    begin
        rnd           = cmo_pkg::scale_round(a_prod_reg);
        b_next.sample = a_sample_reg;
        b_next.sat    = 1'b0;
        if (rnd[36:31] == {6{rnd[36]}})
        begin
            b_next.scaled = rnd[31:0];
        end
        else
        begin
            // saturate towards the sign of the product
            b_next.sat    = 1'b1;
            b_next.scaled = rnd[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sample_reg <= a_sample_next;
        a_prod_reg   <= a_prod_next;
        b_reg        <= b_next;
    end

    assign lane_b = b_reg;

endmodule
`default_nettype wire

[rtl/cmo_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmo_merge
// Combine the lane results into the output frame: channel moves, the add,
// clamping, the new channel count and the overflow flag. Holds the output
// register.
// ----------------------------------------------------------------------------
module cmo_merge #(
    parameter int CH_LIMIT = cmo_pkg::CH_LIMIT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid_b,
    input  wire cmo_pkg::ctrl_t     ctrl_b,
    input  wire cmo_pkg::lane_t     lane_b [cmo_pkg::LANES],
    input  wire logic signed [31:0] hi_b,
    input  wire logic signed [31:0] lo_b,
    output logic                    done,
    output logic signed [31:0]      out_sample [cmo_pkg::LANES],
    output logic [3:0]              out_channels,
    output logic                    overflow_flag,
    output logic                    out_last
);

    localparam logic [3:0] CNT_MAX = 4'(CH_LIMIT);

    logic signed [31:0] s      [cmo_pkg::LANES];
    logic signed [31:0] up_s   [cmo_pkg::LANES];
    logic signed [31:0] dn_s   [cmo_pkg::LANES];
    logic signed [31:0] t      [cmo_pkg::LANES];
    logic signed [31:0] smp_next [cmo_pkg::LANES];
    logic signed [31:0] smp_reg  [cmo_pkg::LANES];
    logic [3:0]         cnt;
    logic [3:0]         cnt_out;
    logic [3:0]         dst_u;
    logic [2:0]         didx;
    logic               dst_all;
    logic               dst_lt;
    logic               dst_le;
    logic               src_ok;
    logic               pair_ok;
    logic               hit;
    logic               ovf;
    logic signed [31:0] addend;
    logic signed [32:0] sum;
    logic signed [31:0] sum_val;
    logic               sum_sat;
    logic               done_reg;
    logic [3:0]         cnt_reg;
    logic               ovf_reg;
    logic               last_reg;

    always_comb
    begin
        cnt     = ctrl_b.cnt;
        dst_all = ctrl_b.dst[4];
        dst_u   = ctrl_b.dst[3:0];
        didx    = ctrl_b.dst[2:0];
        dst_lt  = !dst_all && (dst_u < cnt);
        dst_le  = !dst_all && (dst_u <= cnt);
        src_ok  = ({1'b0, ctrl_b.src} < cnt);
        pair_ok = src_ok && dst_lt;

        for (int i = 0; i < cmo_pkg::LANES; i++)
        begin
            s[i] = lane_b[i].sample;
        end
        up_s[0] = 32'sd0;
        for (int i = 1; i < cmo_pkg::LANES; i++)
        begin
            up_s[i] = s[i - 1];
        end
        for (int i = 0; i < cmo_pkg::LANES - 1; i++)
        begin
            dn_s[i] = s[i + 1];
        end
        dn_s[cmo_pkg::LANES - 1] = 32'sd0;

        addend  = lane_b[ctrl_b.src].scaled;
        sum     = {s[didx][31], s[didx]} + {addend[31], addend};
        sum_sat = (sum[32] != sum[31]);
        sum_val = sum_sat ? (sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sum[31:0];
    end

    always_comb
    begin
        ovf     = 1'b0;
        cnt_out = cnt;
        for (int i = 0; i < cmo_pkg::LANES; i++)
        begin
            t[i] = s[i];
            hit  = (4'(i) < cnt) && (dst_all || (dst_u == 4'(i)));
            case (ctrl_b.mode)
                cmo_pkg::MODE_SWAP:
                begin
                    if (pair_ok && (4'(i) == dst_u))
                    begin
                        t[i] = s[ctrl_b.src];
                    end
                    else if (pair_ok && (3'(i) == ctrl_b.src))
                    begin
                        t[i] = s[didx];
                    end
                end
                cmo_pkg::MODE_ADD:
                begin
                    if (pair_ok && (4'(i) == dst_u))
                    begin
                        t[i] = sum_val;
                    end
                end
                cmo_pkg::MODE_VOLUME:
                begin
                    if (hit)
                    begin
                        t[i] = lane_b[i].scaled;
                        ovf  = ovf | lane_b[i].sat;
                    end
                end
                cmo_pkg::MODE_LIMIT:
                begin
                    if (hit && (s[i] > hi_b))
                    begin
                        t[i] = hi_b;
                    end
                    else if (hit && (s[i] < lo_b))
                    begin
                        t[i] = lo_b;
                    end
                end
                cmo_pkg::MODE_UPMIX:
                begin
                    if (dst_le && (4'(i) == dst_u))
                    begin
                        t[i] = 32'sd0;
                    end
                    else if (dst_le && (4'(i) > dst_u))
                    begin
                        t[i] = up_s[i];
                    end
                end
                cmo_pkg::MODE_DOWNMIX:
                begin
                    if (dst_lt && (4'(i) >= dst_u))
                    begin
                        t[i] = dn_s[i];
                    end
                end
                default:
                begin
                    t[i] = s[i];
                end
            endcase
        end

        case (ctrl_b.mode)
            cmo_pkg::MODE_ADD:
            begin
                if (pair_ok)
                begin
                    ovf = lane_b[ctrl_b.src].sat | sum_sat;
                end
            end
            cmo_pkg::MODE_UPMIX:
            begin
                // drop the last channel when the frame is already full
                if (dst_le && (cnt >= CNT_MAX))
                begin
                    ovf = 1'b1;
                end
                else if (dst_le)
                begin
                    cnt_out = cnt + 4'd1;
                end
            end
            cmo_pkg::MODE_DOWNMIX:
            begin
                if (dst_lt)
                begin
                    cnt_out = cnt - 4'd1;
                end
            end
            cmo_pkg::MODE_KILLMIX:
            begin
                if (dst_lt)
                begin
                    cnt_out = dst_u;
                end
            end
            default:
            begin
                cnt_out = cnt;
            end
        endcase

        for (int i = 0; i < cmo_pkg::LANES; i++)
        begin
            smp_next[i] = (4'(i) < cnt_out) ? t[i] : 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_b;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        cnt_reg  <= cnt_out;
        ovf_reg  <= ovf;
        last_reg <= ctrl_b.last;
    end

    assign done          = done_reg;
    assign out_sample    = smp_reg;
    assign out_channels  = cnt_reg;
    assign overflow_flag = ovf_reg;
    assign out_last      = last_reg;

endmodule
`default_nettype wire

[rtl/channel_mix_op_frame_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// channel_mix_op_frame_core
// Audio channel mixer: applies one configured mix operation to each frame of
// up to eight fixed-point samples.
//
//   channel   signals                                       handshake
//   frame in  in_sample_0..7, in_last                        start, busy
//   frame out out_sample_0..7, out_channels, overflow_flag,  done
//             out_last
//   config    reg_index, write_data                          write_en
//
// One frame per cycle; done follows start through the lane multiply register,
// the lane round and saturate register and the merge output register.
// busy stays low: every stage advances on each clock.
// The receiver cannot stall; each word is on the outputs for one cycle only.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module channel_mix_op_frame_core #(
    parameter int CH_LIMIT = cmo_pkg::CH_LIMIT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               write_en,
    input  wire logic [2:0]         reg_index,
    input  wire logic [15:0]        write_data,
    input  wire logic signed [31:0] in_sample_0,
    input  wire logic signed [31:0] in_sample_1,
    input  wire logic signed [31:0] in_sample_2,
    input  wire logic signed [31:0] in_sample_3,
    input  wire logic signed [31:0] in_sample_4,
    input  wire logic signed [31:0] in_sample_5,
    input  wire logic signed [31:0] in_sample_6,
    input  wire logic signed [31:0] in_sample_7,
    input  wire logic               in_last,
    output logic                    done,
    output logic signed [31:0]      out_sample_0,
    output logic signed [31:0]      out_sample_1,
    output logic signed [31:0]      out_sample_2,
    output logic signed [31:0]      out_sample_3,
    output logic signed [31:0]      out_sample_4,
    output logic signed [31:0]      out_sample_5,
    output logic signed [31:0]      out_sample_6,
    output logic signed [31:0]      out_sample_7,
    output logic [3:0]              out_channels,
    output logic                    overflow_flag,
    output logic                    out_last
);

    localparam logic [3:0] CNT_MAX = 4'(CH_LIMIT);

    logic [2:0]         op_mode_reg;
    logic [3:0]         channels_in_reg;
    logic [2:0]         src_channel_reg;
    logic signed [4:0]  dst_channel_reg;
    logic signed [15:0] gain_reg;

    logic               accept;
    logic [3:0]         cnt_cap;
    cmo_pkg::ctrl_t     ctrl_next;
    cmo_pkg::ctrl_t     ctrl_a_reg;
    cmo_pkg::ctrl_t     ctrl_b_reg;
    logic               valid_a_reg;
    logic               valid_b_reg;

    logic signed [47:0] hi_prod_next;
    logic signed [47:0] lo_prod_next;
    logic signed [47:0] hi_prod_reg;
    logic signed [47:0] lo_prod_reg;
    logic signed [36:0] hi_rnd;
    logic signed [36:0] lo_rnd;
    logic signed [31:0] hi_b_reg;
    logic signed [31:0] lo_b_reg;

    logic signed [31:0] in_s    [cmo_pkg::LANES];
    cmo_pkg::lane_t     lane_b  [cmo_pkg::LANES];
    logic signed [31:0] out_s   [cmo_pkg::LANES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg     <= 3'(cmo_pkg::MODE_VOLUME);
            channels_in_reg <= 4'd2;
            src_channel_reg <= 3'd0;
            dst_channel_reg <= -5'sd1;
            gain_reg        <= 16'sd4096;
        end
        else if (write_en)
        begin
            case (reg_index)
                cmo_pkg::REG_OP_MODE:     op_mode_reg     <= write_data[2:0];
                cmo_pkg::REG_CHANNELS_IN: channels_in_reg <= write_data[3:0];
                cmo_pkg::REG_SRC_CHANNEL: src_channel_reg <= write_data[2:0];
                cmo_pkg::REG_DST_CHANNEL: dst_channel_reg <= write_data[4:0];
                cmo_pkg::REG_GAIN:        gain_reg        <= write_data;
                default:                  op_mode_reg     <= op_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cnt_cap        = (channels_in_reg > CNT_MAX) ? CNT_MAX : channels_in_reg;
        ctrl_next.mode = op_mode_reg;
        ctrl_next.cnt  = cnt_cap;
        ctrl_next.src  = src_channel_reg;
        ctrl_next.dst  = dst_channel_reg;
        ctrl_next.last = in_last;
        hi_prod_next   = cmo_pkg::FULL_POS * gain_reg;
        lo_prod_next   = cmo_pkg::FULL_NEG * gain_reg;
        hi_rnd         = cmo_pkg::scale_round(hi_prod_reg);
        lo_rnd         = cmo_pkg::scale_round(lo_prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= accept;
            valid_b_reg <= valid_a_reg;
        end
    end

    // thresholds follow the word so a gain change never mixes into it
    always_ff @(posedge clk)
    begin
        ctrl_a_reg  <= ctrl_next;
        ctrl_b_reg  <= ctrl_a_reg;
        hi_prod_reg <= hi_prod_next;
        lo_prod_reg <= lo_prod_next;
        hi_b_reg    <= hi_rnd[31:0];
        lo_b_reg    <= lo_rnd[31:0];
    end

    assign in_s[0] = in_sample_0;
    assign in_s[1] = in_sample_1;
    assign in_s[2] = in_sample_2;
    assign in_s[3] = in_sample_3;
    assign in_s[4] = in_sample_4;
    assign in_s[5] = in_sample_5;
    assign in_s[6] = in_sample_6;
    assign in_s[7] = in_sample_7;

    for (genvar g = 0; g < cmo_pkg::LANES; g++)
    begin : g_lane
        cmo_lane u_lane (
            .clk    (clk),
            .sample (in_s[g]),
            .keep   (4'(g) < cnt_cap),
            .gain   (gain_reg),
            .lane_b (lane_b[g])
        );
    end

    cmo_merge #(
        .CH_LIMIT (CH_LIMIT)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_b       (valid_b_reg),
        .ctrl_b        (ctrl_b_reg),
        .lane_b        (lane_b),
        .hi_b          (hi_b_reg),
        .lo_b          (lo_b_reg),
        .done          (done),
        .out_sample    (out_s),
        .out_channels  (out_channels),
        .overflow_flag (overflow_flag),
        .out_last      (out_last)
    );

    assign out_sample_0 = out_s[0];
    assign out_sample_1 = out_s[1];
    assign out_sample_2 = out_s[2];
    assign out_sample_3 = out_s[3];
    assign out_sample_4 = out_s[4];
    assign out_sample_5 = out_s[5];
    assign out_sample_6 = out_s[6];
    assign out_sample_7 = out_s[7];

endmodule
`default_nettype wire

[sim/tb_channel_mix_op_frame_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_mix_op_frame_core
// Self-checking bench for the channel mixer. A queue of frames feeds a
// clocked driver with random gaps; every accepted frame is run through a
// behavioural mixer to get the expected output word, and a clocked monitor
// compares each done word with the oldest expectation, field by field.
// A short directed set covers every mix mode and its edge cases, then
// random phases sweep the register settings between drained intervals.
// ----------------------------------------------------------------------------
module tb_channel_mix_op_frame_core;

    localparam int          PIPE_CYCLES = 3;
    localparam int          MAX_CH      = cmo_pkg::CH_LIMIT_DEF;
    localparam logic [2:0]  MODE_UNUSED = 3'd7;

    typedef enum int {
        PAT_RANDOM,
        PAT_MAX,
        PAT_MIN,
        PAT_NEAR_FS,
        PAT_SMALL,
        PAT_ALT
    } pattern_t;

    typedef struct packed {
        logic [7:0][31:0] smp;
        logic             last;
        logic             hold_off;
    } frame_t;

    typedef struct packed {
        logic [7:0][31:0] smp;
        logic [3:0]       chans;
        logic             ovf;
        logic             last;
    } mix_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic               write_en   = 1'b0;
    logic [2:0]         reg_index  = cmo_pkg::REG_OP_MODE;
    logic [15:0]        write_data = '0;
    logic signed [31:0] in_sample_0 = '0;
    logic signed [31:0] in_sample_1 = '0;
    logic signed [31:0] in_sample_2 = '0;
    logic signed [31:0] in_sample_3 = '0;
    logic signed [31:0] in_sample_4 = '0;
    logic signed [31:0] in_sample_5 = '0;
    logic signed [31:0] in_sample_6 = '0;
    logic signed [31:0] in_sample_7 = '0;
    logic               in_last     = 1'b0;
    logic               busy;
    logic               done;
    logic signed [31:0] out_sample_0;
    logic signed [31:0] out_sample_1;
    logic signed [31:0] out_sample_2;
    logic signed [31:0] out_sample_3;
    logic signed [31:0] out_sample_4;
    logic signed [31:0] out_sample_5;
    logic signed [31:0] out_sample_6;
    logic signed [31:0] out_sample_7;
    logic [3:0]         out_channels;
    logic               overflow_flag;
    logic               out_last;

    // Shadow of the mixer registers, reset values first
    logic [2:0]         cfg_mode  = cmo_pkg::MODE_VOLUME;
    logic [3:0]         cfg_chans = 4'd2;
    logic [2:0]         cfg_src   = 3'd0;
    logic signed [4:0]  cfg_dst   = -5'sd1;
    logic signed [15:0] cfg_gain  = 16'sd4096;

    frame_t      pending_frames[$];
    mix_t        expected_mix[$];
    frame_t      cur_frame;
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    int unsigned fail_count = 0;
    logic        all_back   = 1'b1;

    channel_mix_op_frame_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .write_en     (write_en),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .in_sample_0  (in_sample_0),
        .in_sample_1  (in_sample_1),
        .in_sample_2  (in_sample_2),
        .in_sample_3  (in_sample_3),
        .in_sample_4  (in_sample_4),
        .in_sample_5  (in_sample_5),
        .in_sample_6  (in_sample_6),
        .in_sample_7  (in_sample_7),
        .in_last      (in_last),
        .done         (done),
        .out_sample_0 (out_sample_0),
        .out_sample_1 (out_sample_1),
        .out_sample_2 (out_sample_2),
        .out_sample_3 (out_sample_3),
        .out_sample_4 (out_sample_4),
        .out_sample_5 (out_sample_5),
        .out_sample_6 (out_sample_6),
        .out_sample_7 (out_sample_7),
        .out_channels (out_channels),
        .overflow_flag(overflow_flag),
        .out_last     (out_last)
    );

    always #10 clk = ~clk;

    // Q3.12 product, round to nearest with ties upward (floor shift)
    function automatic longint q12_scale(input longint v, input longint g);
        return (v * g + 64'sd2048) >>> 12;
    endfunction

    function automatic longint clip32(input longint v, inout logic ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic mix_t mix_frame(input frame_t f);
        longint s [8];
        longint t [8];
        longint g;
        longint hi;
        longint lo;
        longint x;
        int     cnt;
        int     src;
        int     dst;
        int     j;
        logic   ovf;
        mix_t   r;
        ovf = 1'b0;
        cnt = (int'(cfg_chans) > MAX_CH) ? MAX_CH : int'(cfg_chans);
        src = int'(cfg_src);
        dst = int'(cfg_dst);
        g   = longint'(cfg_gain);
        for (int i = 0; i < 8; i++)
            s[i] = (i < cnt) ? longint'($signed(f.smp[i])) : 64'sd0;
        case (cfg_mode)
            cmo_pkg::MODE_SWAP:
                if (src < cnt && dst >= 0 && dst < cnt)
                begin
                    x      = s[dst];
                    s[dst] = s[src];
                    s[src] = x;
                end
            cmo_pkg::MODE_ADD:
                if (src < cnt && dst >= 0 && dst < cnt)
                begin
                    x      = clip32(q12_scale(s[src], g), ovf);
                    s[dst] = clip32(s[dst] + x, ovf);
                end
            cmo_pkg::MODE_VOLUME:
                for (int i = 0; i < cnt; i++)
                    if (dst < 0 || i == dst)
                        s[i] = clip32(q12_scale(s[i], g), ovf);
            cmo_pkg::MODE_LIMIT:
            begin
                hi = q12_scale(longint'(cmo_pkg::FULL_POS), g);
                lo = q12_scale(longint'(cmo_pkg::FULL_NEG), g);
                for (int i = 0; i < cnt; i++)
                begin
                    if (dst < 0 || i == dst)
                    begin
                        if (s[i] > hi)
                            s[i] = hi;
                        else if (s[i] < lo)
                            s[i] = lo;
                    end
                end
            end
            cmo_pkg::MODE_UPMIX:
                if (dst >= 0 && dst <= cnt)
                begin
                    j = 0;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (i == dst)
                            t[i] = 64'sd0;
                        else
                        begin
                            t[i] = s[j];
                            j++;
                        end
                    end
                    s = t;
                    // past the top lane: drop the last channel and flag it
                    if (cnt + 1 > MAX_CH)
                        ovf = 1'b1;
                    else
                        cnt++;
                end
            cmo_pkg::MODE_DOWNMIX:
                if (dst >= 0 && dst < cnt)
                begin
                    for (int i = dst; i < cnt - 1; i++)
                        s[i] = s[i + 1];
                    cnt--;
                end
            cmo_pkg::MODE_KILLMIX:
                if (dst >= 0 && dst < cnt)
                    cnt = dst;
            default:
                ;
        endcase
        for (int i = 0; i < 8; i++)
            r.smp[i] = (i < cnt) ? 32'(s[i]) : 32'd0;
        r.chans = 4'(cnt);
        r.ovf   = ovf;
        r.last  = f.last;
        return r;
    endfunction

    function automatic frame_t make_frame(input pattern_t pat);
        frame_t      f;
        logic [31:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r = $urandom;
            case (pat)
                PAT_MAX:     f.smp[i] = 32'h7fff_ffff;
                PAT_MIN:     f.smp[i] = 32'h8000_0000;
                PAT_NEAR_FS: f.smp[i] = {{7{r[24]}}, r[24:0]};
                PAT_SMALL:   f.smp[i] = {{19{r[12]}}, r[12:0]};
                PAT_ALT:     f.smp[i] = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
                default:     f.smp[i] = r;
            endcase
        end
        f.last     = 1'($urandom_range(0, 1));
        f.hold_off = 1'b0;
        return f;
    endfunction

    // Gap after each word; now and then a run of back-to-back words
    function automatic int unsigned draw_gap();
        if (burst_left != 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(10, 60);
        return $urandom_range(0, 17);
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    // Wait for every word to come back, then let the pipe settle
    task automatic wait_idle();
        while (pending_frames.size() != 0 || start || expected_mix.size() != 0)
            @(negedge clk);
        repeat (PIPE_CYCLES + 2) @(negedge clk);
    endtask

    task automatic load_config(input logic [2:0] mode, input logic [3:0] chans,
                               input logic [2:0] src, input logic signed [4:0] dst,
                               input logic signed [15:0] g);
        logic [2:0]  idx [5];
        logic [15:0] val [5];
        idx = '{cmo_pkg::REG_OP_MODE, cmo_pkg::REG_CHANNELS_IN, cmo_pkg::REG_SRC_CHANNEL,
                cmo_pkg::REG_DST_CHANNEL, cmo_pkg::REG_GAIN};
        val = '{{13'd0, mode}, {12'd0, chans}, {13'd0, src}, {{11{dst[4]}}, dst}, g};
        for (int k = 0; k < 5; k++)
        begin
            @(posedge clk);
            write_en   <= 1'b1;
            reg_index  <= idx[k];
            write_data <= val[k];
        end
        @(posedge clk);
        write_en  <= 1'b0;
        cfg_mode  = mode;
        cfg_chans = chans;
        cfg_src   = src;
        cfg_dst   = dst;
        cfg_gain  = g;
    endtask

    task automatic directed(input logic [2:0] mode, input logic [3:0] chans,
                            input logic [2:0] src, input logic signed [4:0] dst,
                            input logic signed [15:0] g, input pattern_t pat);
        load_config(mode, chans, src, dst, g);
        pending_frames.push_back(make_frame(pat));
        wait_idle();
    endtask

    always @(negedge clk)
        all_back <= (expected_mix.size() == 0);

    // Driver
    always @(posedge clk)
    begin
        logic taken;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
                expected_mix.push_back(mix_frame(cur_frame));
            if (start && !taken)
                ;   // hold the word until it is taken
            else if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_frames.size() != 0
                     && (!pending_frames[0].hold_off || (all_back && !taken)))
            begin
                cur_frame   = pending_frames.pop_front();
                in_sample_0 <= cur_frame.smp[0];
                in_sample_1 <= cur_frame.smp[1];
                in_sample_2 <= cur_frame.smp[2];
                in_sample_3 <= cur_frame.smp[3];
                in_sample_4 <= cur_frame.smp[4];
                in_sample_5 <= cur_frame.smp[5];
                in_sample_6 <= cur_frame.smp[6];
                in_sample_7 <= cur_frame.smp[7];
                in_last     <= cur_frame.last;
                start       <= 1'b1;
                gap_left    = draw_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        mix_t got;
        mix_t want;
        if (rst_n && done)
        begin
            got.smp   = {out_sample_7, out_sample_6, out_sample_5, out_sample_4,
                         out_sample_3, out_sample_2, out_sample_1, out_sample_0};
            got.chans = out_channels;
            got.ovf   = overflow_flag;
            got.last  = out_last;
            if (expected_mix.size() == 0)
                flag_error("output word with nothing expected");
            else
            begin
                want = expected_mix.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got.smp[i] !== want.smp[i])
                        flag_error($sformatf("out_sample_%0d: expected %0d, got %0d", i,
                                             $signed(want.smp[i]), $signed(got.smp[i])));
                if (got.chans !== want.chans)
                    flag_error($sformatf("out_channels: expected %0d, got %0d",
                                         want.chans, got.chans));
                if (got.ovf !== want.ovf)
                    flag_error($sformatf("overflow_flag: expected %0b, got %0b",
                                         want.ovf, got.ovf));
                if (got.last !== want.last)
                    flag_error($sformatf("out_last: expected %0b, got %0b",
                                         want.last, got.last));
            end
        end
    end

    initial
    begin
        logic [2:0]         r_mode;
        logic [3:0]         r_chans;
        logic signed [4:0]  r_dst;
        logic signed [15:0] r_gain;
        frame_t             f;
        int unsigned        pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset values: unity volume on two channels
        pending_frames.push_back(make_frame(PAT_ALT));
        wait_idle();

        directed(cmo_pkg::MODE_SWAP,    4'd8,  3'd0, 5'sd7,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_SWAP,    4'd8,  3'd3, 5'sd8,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_SWAP,    4'd4,  3'd7, 5'sd0,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_SWAP,    4'd15, 3'd7, 5'sd0,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_ADD,     4'd8,  3'd1, 5'sd0,  16'sd32767, PAT_MAX);
        directed(cmo_pkg::MODE_ADD,     4'd8,  3'd2, 5'sd5,  -16'sd32768, PAT_MIN);
        directed(cmo_pkg::MODE_ADD,     4'd3,  3'd0, 5'sd2,  16'sd2048,  PAT_RANDOM);
        directed(cmo_pkg::MODE_VOLUME,  4'd8,  3'd0, -5'sd1, -16'sd32768, PAT_ALT);
        directed(cmo_pkg::MODE_VOLUME,  4'd8,  3'd0, 5'sd3,  16'sd2048,  PAT_SMALL);
        directed(cmo_pkg::MODE_VOLUME,  4'd5,  3'd0, 5'sd9,  16'sd0,     PAT_RANDOM);
        directed(cmo_pkg::MODE_VOLUME,  4'd0,  3'd0, -5'sd1, 16'sd32767, PAT_RANDOM);
        directed(cmo_pkg::MODE_LIMIT,   4'd8,  3'd0, -5'sd1, 16'sd4096,  PAT_ALT);
        directed(cmo_pkg::MODE_LIMIT,   4'd8,  3'd0, -5'sd1, -16'sd4096, PAT_NEAR_FS);
        directed(cmo_pkg::MODE_LIMIT,   4'd6,  3'd0, 5'sd2,  16'sd2048,  PAT_NEAR_FS);
        directed(cmo_pkg::MODE_UPMIX,   4'd3,  3'd0, 5'sd0,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_UPMIX,   4'd5,  3'd0, 5'sd5,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_UPMIX,   4'd8,  3'd0, 5'sd4,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_UPMIX,   4'd4,  3'd0, 5'sd15, 16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_DOWNMIX, 4'd8,  3'd0, 5'sd0,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_DOWNMIX, 4'd8,  3'd0, 5'sd7,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_DOWNMIX, 4'd6,  3'd0, -5'sd1, 16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_KILLMIX, 4'd8,  3'd0, 5'sd0,  16'sd4096,  PAT_RANDOM);
        directed(cmo_pkg::MODE_KILLMIX, 4'd8,  3'd0, -5'sd16, 16'sd4096, PAT_RANDOM);
        directed(cmo_pkg::MODE_KILLMIX, 4'd5,  3'd0, 5'sd3,  16'sd4096,  PAT_RANDOM);
        directed(MODE_UNUSED,           4'd8,  3'd5, 5'sd1,  16'sd4096,  PAT_RANDOM);

        for (int phase = 0; phase < 40; phase++)
        begin
            pick   = $urandom_range(0, 20);
            r_mode = (pick == 20) ? MODE_UNUSED : 3'(pick % 7);
            r_chans = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            pick = $urandom_range(0, 9);
            if (pick < 3)
                r_dst = -5'sd1;
            else if (pick == 9)
                r_dst = 5'($urandom);
            else
                r_dst = 5'($urandom_range(0, 8));
            case ($urandom_range(0, 7))
                0:       r_gain = 16'sd4096;
                1:       r_gain = 16'sd0;
                2:       r_gain = 16'sd32767;
                3:       r_gain = -16'sd32768;
                4:       r_gain = -16'sd4096;
                5:       r_gain = 16'($signed($urandom_range(0, 16384)) - 8192);
                default: r_gain = 16'($urandom);
            endcase
            load_config(r_mode, r_chans, 3'($urandom), r_dst, r_gain);
            for (int k = 0; k < 25; k++)
            begin
                f = make_frame(pattern_t'($urandom_range(0, 5)));
                // now and then hold off until the pipe has emptied
                f.hold_off = ($urandom_range(0, 39) == 0);
                pending_frames.push_back(f);
            end
            wait_idle();
        end

        repeat (PIPE_CYCLES + 5) @(posedge clk);
        if (fail_count == 0 && expected_mix.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
